// ===== hw/rtl/sfe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared types and constants for the SBUS frame encoder.
// ----------------------------------------------------------------------------
package sfe_pkg;

  localparam int VAL_W       = 11;
  localparam int ACC_W       = 18;
  localparam int HELD_W      = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] HDR_BYTE = 8'h0F;
  localparam logic [7:0] FTR_BYTE = 8'h00;

  localparam logic signed [VAL_W-1:0] POS_MIN = -11'sd1000;
  localparam logic signed [VAL_W-1:0] POS_MAX = 11'sd1000;
  localparam logic [VAL_W-1:0]        SB_MIN  = 11'd173;

  // floor(span * 1638 / 2000) == (span * MAP_MULT) >> MAP_SHIFT for span 0..2000
  localparam logic [19:0] MAP_MULT  = 20'd858784;
  localparam int          MAP_SHIFT = 20;
  localparam int          PROD_W    = VAL_W + 20;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             first;
    logic             last;
    logic             lost;
    logic             fs;
  } sfe_item_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR,
    PH_DATA,
    PH_STAT,
    PH_FTR
  } sfe_phase_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sfe_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfe_front
// Accepts channel items, maps them to the SBUS range and tags frame position.
// ----------------------------------------------------------------------------
module sfe_front #(
  parameter int NUM_CHANNELS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [10:0]         in_channel_value,
  input  wire logic                       in_signal_lost,
  input  wire logic                       in_failsafe,
  input  wire logic                       q_full,
  output logic                            q_push,
  output sfe_pkg::sfe_item_t              q_item
);
  import sfe_pkg::*;

  localparam int CNT_W = $clog2(NUM_CHANNELS);
  localparam logic [CNT_W-1:0] LAST_CH = CNT_W'(NUM_CHANNELS - 1);

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [VAL_W-1:0] clamped;
  logic signed [VAL_W:0]   span_s;
  logic [VAL_W-1:0]        span;
  logic [PROD_W-1:0]       prod;
  logic                    is_last;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    if (in_channel_value < POS_MIN) begin
      clamped = POS_MIN;
    end else if (in_channel_value > POS_MAX) begin
      clamped = POS_MAX;
    end else begin
      clamped = in_channel_value;
    end
    span_s = {clamped[VAL_W-1], clamped} - {POS_MIN[VAL_W-1], POS_MIN};
    span   = span_s[VAL_W-1:0];
    prod   = PROD_W'(span) * PROD_W'(MAP_MULT);
  end

  assign is_last = (cnt_r == LAST_CH);

  always_comb begin
    q_item.value = prod[MAP_SHIFT +: VAL_W] + SB_MIN;
    q_item.first = (cnt_r == '0);
    q_item.last  = is_last;
    q_item.lost  = in_signal_lost;
    q_item.fs    = in_failsafe;
    cnt_nxt      = cnt_r;
    if (q_push) begin
      cnt_nxt = is_last ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sfe_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfe_queue
// Short FIFO of mapped channel items between front and back.
// ----------------------------------------------------------------------------
module sfe_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire sfe_pkg::sfe_item_t push_item,
  input  wire logic               pop,
  output logic                    full,
  output logic                    empty,
  output sfe_pkg::sfe_item_t      head
);
  import sfe_pkg::*;

  sfe_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sfe_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfe_back
// Packs mapped values into the bit accumulator and emits frame bytes.
// ----------------------------------------------------------------------------
module sfe_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire sfe_pkg::sfe_item_t q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    out_last_of_run,
  output logic                    out_frame_end
);
  import sfe_pkg::*;

  sfe_phase_t         phase_r, phase_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt, base_acc;
  logic [HELD_W-1:0]  held_r, held_nxt, base_held, held_dec;
  logic               cur_last_r, cur_last_nxt;
  logic               cur_lost_r, cur_lost_nxt;
  logic               cur_fs_r, cur_fs_nxt;
  logic               vld_r, vld_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic               lor_r, lor_nxt;
  logic               fend_r, fend_nxt;
  logic               emit, done;
  logic [7:0]         emit_byte;
  logic               emit_fend;

  assign out_valid       = vld_r;
  assign out_byte        = byte_r;
  assign out_last_of_run = lor_r;
  assign out_frame_end   = fend_r;

  assign emit     = (phase_r != PH_IDLE) && (!vld_r || !out_stall);
  assign held_dec = held_r - HELD_W'(8);

  always_comb begin
    phase_nxt    = phase_r;
    base_acc     = acc_r;
    base_held    = held_r;
    cur_last_nxt = cur_last_r;
    cur_lost_nxt = cur_lost_r;
    cur_fs_nxt   = cur_fs_r;
    done         = 1'b0;
    emit_byte    = FTR_BYTE;
    emit_fend    = 1'b0;

    if (emit) begin
      case (phase_r)
        PH_HDR: begin
          emit_byte = HDR_BYTE;
          phase_nxt = PH_DATA;
        end
        PH_DATA: begin
          emit_byte = acc_r[7:0];
          base_acc  = {8'd0, acc_r[ACC_W-1:8]};
          base_held = held_dec;
          if (held_dec >= HELD_W'(8)) begin
            phase_nxt = PH_DATA;
          end else if (cur_last_r) begin
            phase_nxt = PH_STAT;
          end else begin
            done      = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        PH_STAT: begin
          emit_byte = {4'd0, cur_fs_r, cur_lost_r, 2'd0};
          phase_nxt = PH_FTR;
        end
        PH_FTR: begin
          emit_byte = FTR_BYTE;
          emit_fend = 1'b1;
          base_acc  = '0;
          base_held = '0;
          done      = 1'b1;
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    // next item is taken as the current one finishes, no bubble
    q_pop    = !q_empty && ((phase_r == PH_IDLE) || done);
    acc_nxt  = base_acc;
    held_nxt = base_held;
    if (q_pop) begin
      acc_nxt      = base_acc | (ACC_W'(q_head.value) << base_held);
      held_nxt     = base_held + HELD_W'(VAL_W);
      cur_last_nxt = q_head.last;
      cur_lost_nxt = q_head.lost;
      cur_fs_nxt   = q_head.fs;
      phase_nxt    = q_head.first ? PH_HDR : PH_DATA;
    end

    vld_nxt  = vld_r;
    byte_nxt = byte_r;
    lor_nxt  = lor_r;
    fend_nxt = fend_r;
    if (emit) begin
      vld_nxt  = 1'b1;
      byte_nxt = emit_byte;
      lor_nxt  = done;
      fend_nxt = emit_fend;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      held_r  <= '0;
      vld_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      held_r  <= held_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_last_r <= cur_last_nxt;
    cur_lost_r <= cur_lost_nxt;
    cur_fs_r   <= cur_fs_nxt;
    byte_r     <= byte_nxt;
    lor_r      <= lor_nxt;
    fend_r     <= fend_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sbus_frame_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbus_frame_encoder
// Builds 25-byte SBUS frames from one signed channel value per transfer.
// ----------------------------------------------------------------------------
// Each input transfer carries one channel position (-1000..1000, clamped),
// mapped to 173..1811 and packed LSB first into the frame. The first channel
// also emits the 0x0F header, the last one the status byte and the 0x00
// footer. Output bytes leave at one per cycle from the packing stage unless
// stalled or out of queued items; a channel causes one or two bytes in the
// middle of a frame, two for the first, four for the last, about 1.6 per
// channel over a whole frame. A four-entry queue between the mapping stage
// and the packer lets input transfers continue while the output is stalled.
// ----------------------------------------------------------------------------
module sbus_frame_encoder #(
  parameter int NUM_CHANNELS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [10:0] in_channel_value,
  input  wire logic               in_signal_lost,
  input  wire logic               in_failsafe,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    out_last_of_run,
  output logic                    out_frame_end
);
  import sfe_pkg::*;

  sfe_item_t push_item;
  sfe_item_t head_item;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  sfe_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_channel_value (in_channel_value),
    .in_signal_lost   (in_signal_lost),
    .in_failsafe      (in_failsafe),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (push_item)
  );

  sfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head_item)
  );

  sfe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (head_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_frame_end   (out_frame_end)
  );

endmodule
`default_nettype wire
